FILE: design/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants of the stepped clamp sequencer
// Word layouts, table rows, register indexes and state codes.
// ----------------------------------------------------------------------------
package scs_pkg;

    // Table sizing.
    localparam int MAX_LEVELS = 16;
    localparam int LVL_W      = $clog2(MAX_LEVELS);
    localparam int CNT_W      = LVL_W + 1;

    // Fixed field widths.
    localparam int DUR_W       = 47;
    localparam int VOLT_W      = 32;
    localparam int TIME_W      = 48;
    localparam int GAIN_W      = 32;
    localparam int DIFF_W      = 34;
    localparam int CNT_FIELD_W = 5;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RESIST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_GAIN   = 2'd2;

    // Largest switch time, and the switch time before the first level.
    localparam logic signed [TIME_W-1:0] TIME_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [TIME_W-1:0] TIME_NONE = -48'sd1;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic [LVL_W-1:0]         level_index;
        logic [DUR_W-1:0]         level_duration;
        logic signed [VOLT_W-1:0] level_voltage;
        logic [DUR_W-1:0]         sample_time;
        logic signed [VOLT_W-1:0] node_voltage;
        logic signed [VOLT_W-1:0] ext_voltage;
    } t_in;

    typedef struct packed {
        logic [LVL_W-1:0]         active_level;
        logic signed [VOLT_W-1:0] clamp_voltage;
        logic                     clamp_on;
        logic signed [TIME_W-1:0] clamp_current;
        logic signed [TIME_W-1:0] rhs_add;
        logic [GAIN_W-1:0]        diag_add;
        logic signed [TIME_W-1:0] chain_end_time;
        logic                     index_error;
    } t_out;

    // Row of the level table: what software wrote for one level.
    typedef struct packed {
        logic [DUR_W-1:0]         duration;
        logic signed [VOLT_W-1:0] voltage;
    } t_parm_row;

    // Row of the switch time table: start and stop of one level.
    typedef struct packed {
        logic signed [TIME_W-1:0] start_time;
        logic signed [TIME_W-1:0] stop_time;
    } t_time_row;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_REBUILD,
        ST_MUL,
        ST_FIN,
        ST_EMIT
    } t_state;

endpackage

FILE: design/scs_ram.sv
// ----------------------------------------------------------------------------
// scs_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module scs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/scs_mulq.sv
// ----------------------------------------------------------------------------
// scs_mulq: rounded Q16.16 product unit
// Sign-magnitude product of a difference and an unsigned gain, rounded
// half up on the magnitude and saturated to 48 bits. One register stage.
// ----------------------------------------------------------------------------
module scs_mulq (
    input  logic                              i_clk,
    input  logic signed [scs_pkg::DIFF_W-1:0] i_d,
    input  logic [scs_pkg::GAIN_W-1:0]        i_g,
    output logic signed [scs_pkg::TIME_W-1:0] o_q
);
    import scs_pkg::*;

    localparam int HI_W  = DIFF_W - 16;
    localparam int PHI_W = HI_W + GAIN_W;
    localparam int PLO_W = 16 + GAIN_W;
    localparam int ACC_W = PHI_W + 2;
    localparam logic [ACC_W-1:0] MAG_LIMIT = ACC_W'(TIME_MAX) + ACC_W'(1);

    logic [DIFF_W-1:0] mag;
    logic              r_neg;
    logic [PHI_W-1:0]  r_hi;
    logic [PLO_W-1:0]  r_lo;
    logic [PLO_W:0]    lo_round;
    logic [ACC_W-1:0]  sum;

    // The magnitude of the most negative difference still fits unsigned.
    assign mag = i_d[DIFF_W-1] ? DIFF_W'(-i_d) : DIFF_W'(i_d);

    always_ff @(posedge i_clk) begin
        r_neg <= i_d[DIFF_W-1];
        r_hi  <= PHI_W'(mag[DIFF_W-1:16]) * PHI_W'(i_g);
        r_lo  <= PLO_W'(mag[15:0]) * PLO_W'(i_g);
    end

    always_comb begin
        lo_round = {1'b0, r_lo} + (PLO_W+1)'(32'h8000);
        sum      = ACC_W'(r_hi) + ACC_W'(lo_round >> 16);
        if (r_neg) begin
            if (sum > MAG_LIMIT) begin
                o_q = -TIME_MAX - TIME_W'(1);
            end else begin
                o_q = -$signed(sum[TIME_W-1:0]);
            end
        end else begin
            if (sum > ACC_W'(TIME_MAX)) begin
                o_q = TIME_MAX;
            end else begin
                o_q = $signed(sum[TIME_W-1:0]);
            end
        end
    end

endmodule

FILE: design/stepped_clamp_sequencer.sv
// ----------------------------------------------------------------------------
// stepped_clamp_sequencer: stepped voltage clamp with a level table
// Holds a chain of clamp levels in two small RAMs, rebuilds the switch times
// on every in-range write and walks a sticky level pointer on every sample with levels.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Word
//  in        input      i_in_valid / o_in_ready     t_in  (write or sample)
//  out       output     o_out_valid / i_out_ready   t_out (one per input word)
//  cfg       input      i_cfg_we, i_cfg_index       i_cfg_data, no wait
//
// The block works on one word at a time. A sample walks the pointer to its
// level in ST_WALK and, when the clamp is on, passes through ST_MUL and
// ST_FIN before ST_EMIT; the pointer walk reads one row of the switch time
// RAM per cycle. A level write rebuilds the switch times in ST_REBUILD, one
// RAM row per level. A rejected write or a sample with no levels goes
// straight to ST_EMIT. Reset needs no clearing pass: the tables are cleared
// through per-row valid bits. A finished word waits in the output register,
// so a stall on the output side holds the block only when a second result
// is ready behind it.
// ----------------------------------------------------------------------------
module stepped_clamp_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  scs_pkg::t_in                       i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output scs_pkg::t_out                      o_out,
    input  logic                               i_cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [scs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import scs_pkg::*;

    // Control state.
    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [GAIN_W-1:0]       r_inv_resist, n_inv_resist;
    logic [GAIN_W-1:0]       r_gain, n_gain;
    logic [MAX_LEVELS-1:0]   r_parm_vld, n_parm_vld;
    logic [MAX_LEVELS-1:0]   r_time_vld, n_time_vld;
    logic [LVL_W-1:0]        r_ptr, n_ptr;
    logic                    r_out_valid, n_out_valid;

    // Payload registers.
    logic [LVL_W-1:0]         r_idx, n_idx;
    logic signed [TIME_W-1:0] r_acc, n_acc;
    t_in                      r_item, n_item;
    t_out                     r_res, n_res;
    t_out                     r_out, n_out;
    logic signed [DIFF_W-1:0] r_d_cur, n_d_cur;
    logic signed [DIFF_W-1:0] r_d_rhs, n_d_rhs;

    // RAM ports.
    logic             parm_we;
    t_parm_row        parm_wdata;
    t_parm_row        parm_q;
    logic             time_we;
    t_time_row        time_wdata;
    t_time_row        time_q;
    logic [LVL_W-1:0] rd_addr;

    // Product unit results.
    logic signed [TIME_W-1:0] cur_q;
    logic signed [TIME_W-1:0] rhs_q;

    // Decode.
    logic                     accept;
    logic                     in_is_write;
    logic                     in_bad_idx;
    logic                     out_free;
    logic [CNT_FIELD_W-1:0]   cfg_cnt;

    logic                     walk_done;
    logic                     walk_on;
    logic [LVL_W-1:0]         walk_ptr;
    t_time_row                row_time;
    logic signed [VOLT_W-1:0] row_volt;
    logic signed [TIME_W-1:0] t_now;
    logic                     ptr_last;

    logic [DUR_W-1:0]         rb_dur;
    logic signed [TIME_W:0]   rb_sum;
    logic signed [TIME_W-1:0] rb_next;
    logic                     rb_last;

    assign accept      = i_in_valid && o_in_ready;
    assign in_is_write = (i_in.op == OP_WRITE);
    assign in_bad_idx  = ({1'b0, i_in.level_index} >= r_count);
    assign out_free    = !r_out_valid || i_out_ready;
    assign cfg_cnt     = i_cfg_data[CNT_FIELD_W-1:0];

    // Level table: duration and voltage of each level.
    scs_ram #(
        .WIDTH ($bits(t_parm_row)),
        .DEPTH (MAX_LEVELS)
    ) u_parm_ram (
        .i_clk   (i_clk),
        .i_we    (parm_we),
        .i_waddr (i_in.level_index),
        .i_wdata (parm_wdata),
        .i_raddr (rd_addr),
        .o_rdata (parm_q)
    );

    // Switch time table: start and stop time of each level.
    scs_ram #(
        .WIDTH ($bits(t_time_row)),
        .DEPTH (MAX_LEVELS)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (r_idx),
        .i_wdata (time_wdata),
        .i_raddr (rd_addr),
        .o_rdata (time_q)
    );

    scs_mulq u_mul_cur (
        .i_clk (i_clk),
        .i_d   (r_d_cur),
        .i_g   (r_inv_resist),
        .o_q   (cur_q)
    );

    scs_mulq u_mul_rhs (
        .i_clk (i_clk),
        .i_d   (r_d_rhs),
        .i_g   (r_gain),
        .o_q   (rhs_q)
    );

    // Pointer walk. Both RAMs were read at r_ptr in the previous cycle. A row
    // that has not been written since the last clear reads as its reset
    // value: switch times of minus one and a voltage of zero. The pointer
    // is always below the level count whenever the count is nonzero.
    always_comb begin
        row_time = time_q;
        if (!r_time_vld[r_ptr]) begin
            row_time.start_time = TIME_NONE;
            row_time.stop_time  = TIME_NONE;
        end
        row_volt = r_parm_vld[r_ptr] ? parm_q.voltage : '0;
        t_now    = $signed({1'b0, r_item.sample_time});
        ptr_last = (({1'b0, r_ptr} + CNT_W'(1)) == r_count);

        walk_done = 1'b0;
        walk_on   = 1'b1;
        walk_ptr  = r_ptr;
        if (t_now < row_time.start_time) begin
            if (r_ptr == '0) begin
                walk_done = 1'b1;
            end else begin
                walk_ptr = r_ptr - LVL_W'(1);
            end
        end else if (t_now < row_time.stop_time) begin
            walk_done = 1'b1;
        end else if (ptr_last) begin
            // Past the end of the chain: the pointer rests on the last level.
            walk_done = 1'b1;
            walk_on   = 1'b0;
        end else begin
            walk_ptr = r_ptr + LVL_W'(1);
        end
    end

    // Rebuild of the switch times, one level per cycle. The level written
    // by this word comes from the held word rather than the RAM, since its
    // row may have been read before the write landed.
    always_comb begin
        if (r_idx == r_item.level_index) begin
            rb_dur = r_item.level_duration;
        end else if (r_parm_vld[r_idx]) begin
            rb_dur = parm_q.duration;
        end else begin
            rb_dur = '0;
        end
        rb_sum = {r_acc[TIME_W-1], r_acc} + $signed({2'b00, rb_dur});
        if (rb_sum > $signed({1'b0, TIME_MAX})) begin
            rb_next = TIME_MAX;
        end else begin
            rb_next = rb_sum[TIME_W-1:0];
        end
        rb_last = (({1'b0, r_idx} + CNT_W'(1)) == r_count);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (in_is_write) begin
                        n_state = in_bad_idx ? ST_EMIT : ST_REBUILD;
                    end else begin
                        n_state = (r_count == '0) ? ST_EMIT : ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    n_state = walk_on ? ST_MUL : ST_EMIT;
                end
            end
            ST_REBUILD: begin
                if (rb_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_MUL: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs: handshake, RAM enables and the shared read address.
    always_comb begin
        o_in_ready = 1'b0;
        parm_we    = 1'b0;
        time_we    = 1'b0;
        rd_addr    = r_ptr;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                parm_we    = accept && in_is_write && !in_bad_idx;
                rd_addr    = (i_in.op == OP_WRITE) ? '0 : r_ptr;
            end
            ST_WALK: begin
                rd_addr = walk_ptr;
            end
            ST_REBUILD: begin
                time_we = 1'b1;
                rd_addr = r_idx + LVL_W'(1);
            end
            default: begin
                rd_addr = r_ptr;
            end
        endcase
    end

    assign parm_wdata.duration   = i_in.level_duration;
    assign parm_wdata.voltage    = i_in.level_voltage;
    assign time_wdata.start_time = r_acc;
    assign time_wdata.stop_time  = rb_next;

    // Datapath next values.
    always_comb begin
        n_count      = r_count;
        n_inv_resist = r_inv_resist;
        n_gain       = r_gain;
        n_parm_vld   = r_parm_vld;
        n_time_vld   = r_time_vld;
        n_ptr        = r_ptr;
        n_idx        = r_idx;
        n_acc        = r_acc;
        n_item       = r_item;
        n_res        = r_res;
        n_d_cur      = r_d_cur;
        n_d_rhs      = r_d_rhs;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_item             = i_in;
                    n_res              = '0;
                    n_res.index_error  = in_is_write && in_bad_idx;
                    n_idx              = '0;
                    n_acc              = TIME_NONE;
                    if (in_is_write && !in_bad_idx) begin
                        n_parm_vld[i_in.level_index] = 1'b1;
                        n_ptr                        = '0;
                    end
                end
            end
            ST_WALK: begin
                n_ptr = walk_ptr;
                if (walk_done) begin
                    n_res.active_level  = r_ptr;
                    n_res.clamp_voltage = row_volt;
                    n_res.clamp_on      = walk_on;
                    n_d_cur = DIFF_W'(row_volt) - DIFF_W'(r_item.node_voltage);
                    n_d_rhs = DIFF_W'(row_volt) - DIFF_W'(r_item.node_voltage)
                            - DIFF_W'(r_item.ext_voltage);
                end
            end
            ST_REBUILD: begin
                n_time_vld[r_idx] = 1'b1;
                n_acc             = rb_next;
                n_idx             = r_idx + LVL_W'(1);
                if (rb_last) begin
                    // The chain ends at the start time of its last level.
                    n_res.chain_end_time = r_acc;
                end
            end
            ST_FIN: begin
                n_res.clamp_current = cur_q;
                n_res.rhs_add       = rhs_q;
                n_res.diag_add      = r_gain;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase

        // Configuration writes must arrive only while the block is idle; unchecked.
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEVEL_COUNT: begin
                    if (cfg_cnt > CNT_FIELD_W'(MAX_LEVELS)) begin
                        n_count = CNT_W'(MAX_LEVELS);
                    end else begin
                        n_count = CNT_W'(cfg_cnt);
                    end
                    n_parm_vld = '0;
                    n_time_vld = '0;
                    n_ptr      = '0;
                end
                CFG_INV_RESIST: begin
                    n_inv_resist = i_cfg_data;
                end
                CFG_NODE_GAIN: begin
                    n_gain = i_cfg_data;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_inv_resist <= GAIN_W'(32'h0001_0000);
            r_gain       <= '0;
            r_parm_vld   <= '0;
            r_time_vld   <= '0;
            r_ptr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_inv_resist <= n_inv_resist;
            r_gain       <= n_gain;
            r_parm_vld   <= n_parm_vld;
            r_time_vld   <= n_time_vld;
            r_ptr        <= n_ptr;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_acc   <= n_acc;
        r_item  <= n_item;
        r_res   <= n_res;
        r_out   <= n_out;
        r_d_cur <= n_d_cur;
        r_d_rhs <= n_d_rhs;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
